/* hw/rtl/jos_pkg.sv */
// jos_pkg: shared widths, defaults and controller states
// for the josephus elimination order block; no dependencies
package jos_pkg;

  localparam int MAX_PEOPLE_DEF = 64;
  localparam int PERSON_W       = 7;
  localparam int STEP_W         = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PRIME,
    ST_ADV,
    ST_MODW,
    ST_EMIT
  } state_t;

endpackage

/* hw/rtl/jos_ram.sv */
// jos_ram: generic single-write, single-read ram with registered read
// read during write to the same address returns the old data; no dependencies
module jos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/jos_mod.sv */
// jos_mod: bit-serial restoring remainder unit, one dividend bit per cycle
// depends on nothing; divisor must be nonzero
module jos_mod #(
  parameter int DIVIDEND_W = 16,
  parameter int DIVISOR_W  = 7,
  parameter int REM_W      = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [REM_W-1:0]      remainder
);

  localparam int BIT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy;
  logic [BIT_W-1:0]      bit_cnt;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  den;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    rem_next;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    shifted = {rem, quo[DIVIDEND_W-1]};
    if (shifted >= {1'b0, den}) begin
      rem_next = shifted - {1'b0, den};
    end else begin
      rem_next = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bit_cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= dividend;
      den     <= divisor;
      rem     <= '0;
      bit_cnt <= BIT_W'(DIVIDEND_W - 1);
    end else if (busy) begin
      quo     <= quo << 1;
      rem     <= rem_next[DIVISOR_W-1:0];
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

  assign remainder = rem[REM_W-1:0];

endmodule

/* hw/rtl/josephus_elimination_order.sv */
// josephus_elimination_order: emits the elimination order of a josephus circle
// operation: builds the successor ram with one entry per person, walks to start_position,
// then per removal takes the step remainder, hops along the ring and emits the word
// one request at a time: the next is taken once the closing word is loaded
// reset (rst, synchronous): controller idle, output word dropped
// depends on jos_pkg, jos_ram, jos_mod
module josephus_elimination_order
  import jos_pkg::*;
#(
  parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PERSON_W-1:0] people_count,
  input  logic [STEP_W-1:0]   step_count,
  input  logic [PERSON_W-1:0] start_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PERSON_W-1:0] person,
  output logic                is_survivor,
  output logic                bad_request,
  output logic                last
);

  // index of a person (zero based) and count of people still in the circle
  localparam int IDX_W  = $clog2(MAX_PEOPLE);
  localparam int LEFT_W = $clog2(MAX_PEOPLE + 1);

  state_t state, state_next;

  // request and walk registers
  logic [IDX_W-1:0]  n_m1;        // people_count - 1
  logic [STEP_W-1:0] m_m1;        // step_count - 1
  logic              bad;         // request rejected
  logic [IDX_W-1:0]  init_idx;    // ram build pointer
  logic [IDX_W-1:0]  cur;         // person counted now
  logic [IDX_W-1:0]  prev;        // its predecessor in the circle
  logic [LEFT_W-1:0] left;        // people still in the circle
  logic [IDX_W-1:0]  hops;        // hops still to walk
  logic              walked;      // hops came from the step remainder

  // ram ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [IDX_W-1:0]  succ;        // successor of cur once primed

  // remainder unit
  logic              mod_start;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_rem;

  // control decodes
  logic              req_bad;
  logic              take;
  logic              out_free;
  logic              out_load;
  logic              final_word;

  assign take     = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // rejection rules for a request
  assign req_bad = (people_count == '0) ||
                   (people_count > PERSON_W'(MAX_PEOPLE)) ||
                   (step_count == '0) ||
                   (start_position == '0) ||
                   (start_position > people_count);

  // a rejected request or the survivor closes the request
  assign final_word = bad || (left == LEFT_W'(1));

  // successor table: entry i holds the zero-based person after person i
  jos_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_PEOPLE)
  ) u_succ_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(succ)
  );

  // (step_count - 1) mod people_left gives the hops to the next removal
  jos_mod #(
    .DIVIDEND_W(STEP_W),
    .DIVISOR_W (LEFT_W),
    .REM_W     (IDX_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (m_m1),
    .divisor  (left),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          state_next = req_bad ? ST_EMIT : ST_INIT;
        end
      end
      ST_INIT: begin
        if (init_idx == n_m1) begin
          state_next = ST_PRIME;
        end
      end
      // wait for the registered ram read of cur, so succ is valid in ST_ADV
      ST_PRIME: state_next = ST_ADV;
      ST_ADV: begin
        if (hops == '0) begin
          if (walked || left == LEFT_W'(1)) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_MODW;
          end
        end
      end
      ST_MODW: begin
        if (mod_done) begin
          state_next = ST_ADV;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = final_word ? ST_IDLE : ST_PRIME;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = init_idx;
    ram_wdata = (init_idx == n_m1) ? '0 : init_idx + 1'b1;
    ram_raddr = cur;
    mod_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_INIT: ram_we = 1'b1;
      ST_PRIME: ;
      ST_ADV: begin
        // chase the pointer one hop per cycle: read the successor of succ
        if (hops != '0) begin
          ram_raddr = succ;
        end else if (!walked && left != LEFT_W'(1)) begin
          mod_start = 1'b1;
        end
      end
      ST_MODW: ;
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          // unlink cur: prev now points past it
          if (!final_word) begin
            ram_we    = 1'b1;
            ram_waddr = prev;
            ram_wdata = succ;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take) begin
          bad      <= req_bad;
          n_m1     <= IDX_W'(people_count - 1'b1);
          m_m1     <= step_count - 1'b1;
          hops     <= IDX_W'(start_position - 1'b1);
          left     <= LEFT_W'(people_count);
          init_idx <= '0;
        end
      end
      ST_INIT: begin
        init_idx <= init_idx + 1'b1;
        if (init_idx == n_m1) begin
          cur    <= '0;
          prev   <= n_m1;
          walked <= 1'b0;
        end
      end
      ST_ADV: begin
        if (hops != '0) begin
          prev <= cur;
          cur  <= succ;
          hops <= hops - 1'b1;
        end
      end
      ST_MODW: begin
        if (mod_done) begin
          hops   <= mod_rem;
          walked <= 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free && !final_word) begin
          cur    <= succ;
          left   <= left - 1'b1;
          walked <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output word register, lets the next request in while a word waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      person      <= bad ? '0 : PERSON_W'(cur) + 1'b1;
      is_survivor <= !bad && (left == LEFT_W'(1));
      bad_request <= bad;
      last        <= final_word;
    end
  end

endmodule

/* hw/rtl/jos_chk.sv */
// jos_chk: port-level checker for josephus_elimination_order, bound to the top
// depends on jos_pkg
module jos_chk
  import jos_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic [PERSON_W-1:0] people_count,
  input logic [STEP_W-1:0]   step_count,
  input logic [PERSON_W-1:0] start_position,
  input logic                out_valid,
  input logic                out_stall,
  input logic [PERSON_W-1:0] person,
  input logic                is_survivor,
  input logic                bad_request,
  input logic                last
);

  // rejected request gives a single closing word with no person
  a_bad_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_request |-> person == '0 && last && !is_survivor)
    else $error("bad request word malformed");

  // survivor closes the request
  a_surv_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_survivor |-> last && !bad_request)
    else $error("survivor word not last");

  // only the survivor or a rejection may close a request
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> is_survivor || bad_request)
    else $error("last word without survivor or rejection");

  // block is busy right after it takes a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(person) && $stable(last))
    else $error("stalled output word changed");

endmodule

bind josephus_elimination_order jos_chk u_jos_chk (.*);

/* tb/josephus_elimination_order_tb.sv */
// josephus_elimination_order_tb: self-checking bench for the josephus elimination order block
// drives requests with random idling, predicts every result word in-bench and checks in order
// depends on jos_pkg and josephus_elimination_order
`timescale 1ns / 100ps

module josephus_elimination_order_tb;
  import jos_pkg::*;

  // one result word as the block presents it
  typedef struct packed {
    logic [PERSON_W-1:0] person;
    logic                is_survivor;
    logic                bad_request;
    logic                last;
  } order_word_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PERSON_W-1:0] people_count = '0;
  logic [STEP_W-1:0]   step_count = '0;
  logic [PERSON_W-1:0] start_position = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PERSON_W-1:0] person;
  logic                is_survivor;
  logic                bad_request;
  logic                last;

  // bench copy of the circle: next seat per zero-based seat, cursor and its predecessor
  logic [5:0] next_seat [MAX_PEOPLE_DEF];
  logic [5:0] cur_seat = '0;
  logic [5:0] prev_seat = '0;
  logic [6:0] seats_left = '0;

  order_word_t pending_order[$];

  // quiet_stretch turns off idling on both sides
  bit quiet_stretch = 1'b0;
  int error_count = 0;
  int words_checked = 0;
  int circles_run = 0;
  int requests_rejected = 0;

  josephus_elimination_order dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .people_count  (people_count),
    .step_count    (step_count),
    .start_position(start_position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .person        (person),
    .is_survivor   (is_survivor),
    .bad_request   (bad_request),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop: leaves plenty of room for full 64-person circles with stalls over the
  // ~140 requests of the run
  initial begin
    #(100_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // move the cursor one seat around the circle
  function automatic void hop_seat();
    prev_seat = cur_seat;
    cur_seat  = next_seat[cur_seat];
  endfunction

  // append one expected word at the tail of the queue
  function automatic void queue_word(input order_word_t w);
    pending_order.insert(pending_order.size(), w);
  endfunction

  // work out the whole elimination order of one request and queue its words
  function automatic void predict_order(input int unsigned n, input int unsigned m,
                                        input int unsigned k);
    int unsigned moves;
    order_word_t w;
    if (n == 0 || n > MAX_PEOPLE_DEF || m == 0 || k == 0 || k > n) begin
      // rejected: a single flagged word, circle state untouched
      w = '{person: '0, is_survivor: 1'b0, bad_request: 1'b1, last: 1'b1};
      queue_word(w);
      requests_rejected++;
      return;
    end
    // rebuild the ring 0 -> 1 -> ... -> n-1 -> 0
    for (int i = 0; i + 1 < n; i++)
      next_seat[i] = 6'(i + 1);
    next_seat[n - 1] = '0;
    cur_seat   = '0;
    prev_seat  = 6'(n - 1);
    seats_left = 7'(n);
    // walk to the start seat
    for (int i = 1; i < k; i++)
      hop_seat();
    while (seats_left > 1) begin
      // a step larger than the circle wraps to the same person
      moves = (m - 1) % seats_left;
      for (int i = 0; i < moves; i++)
        hop_seat();
      w = '{person: 7'(cur_seat) + 7'd1, is_survivor: 1'b0, bad_request: 1'b0, last: 1'b0};
      queue_word(w);
      // unlink the removed seat, counting resumes at its successor
      next_seat[prev_seat] = next_seat[cur_seat];
      cur_seat = next_seat[prev_seat];
      seats_left--;
    end
    w = '{person: 7'(cur_seat) + 7'd1, is_survivor: 1'b1, bad_request: 1'b0, last: 1'b1};
    queue_word(w);
    circles_run++;
  endfunction

  // present one request, hold it through stalls, predict once it is taken
  task automatic send_request(input int unsigned n, input int unsigned m,
                              input int unsigned k);
    // random idle before the word goes up; valid is lowered and raised in different steps
    if (!quiet_stretch && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    people_count   <= PERSON_W'(n);
    step_count     <= STEP_W'(m);
    start_position <= PERSON_W'(k);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_order(n & 32'h7F, m & 32'hFFFF, k & 32'h7F);
  endtask

  // receiver: random stall, none during the quiet stretch
  always @(posedge clk) begin
    if (quiet_stretch)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < 23);
  end

  // result checker: every accepted word against the oldest prediction
  always @(posedge clk) begin
    order_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_order.size() == 0) begin
        $error("unexpected word: person %0d survivor %0b bad %0b last %0b",
               person, is_survivor, bad_request, last);
        error_count++;
      end else begin
        want = pending_order.pop_front();
        words_checked++;
        if (person !== want.person) begin
          $error("person: expected %0d, got %0d", want.person, person);
          error_count++;
        end
        if (is_survivor !== want.is_survivor) begin
          $error("is_survivor: expected %0b, got %0b", want.is_survivor, is_survivor);
          error_count++;
        end
        if (bad_request !== want.bad_request) begin
          $error("bad_request: expected %0b, got %0b", want.bad_request, bad_request);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          error_count++;
        end
      end
    end
  end

  // lone person and two-person circles
  task automatic test_small_circles();
    send_request(1, 1, 1);
    send_request(1, 65535, 1);
    send_request(2, 2, 2);
    send_request(2, 1, 1);
  endtask

  // full-size circles with the step extremes and the farthest start
  task automatic test_full_circles();
    send_request(MAX_PEOPLE_DEF, 1, 1);
    send_request(MAX_PEOPLE_DEF, 65535, MAX_PEOPLE_DEF);
    send_request(MAX_PEOPLE_DEF, 32768, 21);
  endtask

  // textbook circles, start at the last seat, step wider than the circle
  task automatic test_classic_circles();
    send_request(7, 3, 1);
    send_request(41, 3, 1);
    send_request(10, 10, 10);
    send_request(5, 65535, 3);
    send_request(42, 21845, 42);
  endtask

  // every way a request can be rejected
  task automatic test_bad_requests();
    send_request(0, 3, 1);                        // empty circle
    send_request(MAX_PEOPLE_DEF + 1, 3, 1);       // one above max
    send_request(127, 65535, 127);                // all ones in every field
    send_request(8, 0, 1);                        // zero step
    send_request(8, 5, 0);                        // zero start
    send_request(8, 5, 9);                        // start past the circle
    send_request(MAX_PEOPLE_DEF, 2, 127);         // start far past a full circle
  endtask

  // mostly well-formed circles of random shape, some malformed ones mixed in
  task automatic test_random_requests(input int count);
    int unsigned n, m, k;
    for (int r = 0; r < count; r++) begin
      // a stretch in the middle runs with no idling on either side
      quiet_stretch = (r >= 40 && r < 70);
      if ($urandom_range(99) < 85) begin
        // keep most circles small so the run stays short
        if ($urandom_range(9) == 0)
          n = $urandom_range(MAX_PEOPLE_DEF, 17);
        else
          n = $urandom_range(16, 1);
        if ($urandom_range(9) < 6)
          m = $urandom_range(8, 1);
        else
          m = $urandom_range(65535, 1);
        k = $urandom_range(n, 1);
      end else begin
        n = $urandom_range(MAX_PEOPLE_DEF, 1);
        m = $urandom_range(65535, 1);
        k = $urandom_range(n, 1);
        case ($urandom_range(3))
          0: n = 0;
          1: n = $urandom_range(127, MAX_PEOPLE_DEF + 1);
          2: m = 0;
          default: k = ($urandom_range(1) == 0) ? 0 : $urandom_range(127, n + 1);
        endcase
      end
      send_request(n, m, k);
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_small_circles();
    test_full_circles();
    test_classic_circles();
    test_bad_requests();
    test_random_requests(120);

    in_valid <= 1'b0;
    // drain, then a tail long enough to catch any stray word
    while (pending_order.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("ran %0d circles and %0d rejected requests, %0d result words checked",
             circles_run, requests_rejected, words_checked);
    $display("sizes 1 to %0d, steps up to 65535, with random idling and stalls",
             MAX_PEOPLE_DEF);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
